// ===== sv/bfhs_pkg.sv =====
// Package for the back/forward history stacks: sizes, function and status codes,
// and the transaction payload types. No dependencies.
`default_nettype none

package bfhs_pkg;

    // Stack geometry; depth is a power of two so the circular index wraps by truncation
    localparam int STACK_DEPTH = 128;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PAGE_W      = 32;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int BCOUNT_W = 7;
    localparam int FCOUNT_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_VISIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BACK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORWARD = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PREV = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_NEXT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CUR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LOST    = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page_id;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   current_page;
        logic                has_current;
        logic [BCOUNT_W-1:0] back_count;
        logic [FCOUNT_W-1:0] forward_count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/back_forward_history_stacks.sv =====
// Top level of the back/forward page history: two stack memories and the
// read-modify-write sequencer around them. Depends on bfhs_pkg.
//
//  channel | ports                      | payload                  | role
//  --------+----------------------------+--------------------------+-------------------
//  s_      | s_valid, s_ready, s_data   | bfhs_pkg::in_item_t      | history command in
//  m_      | m_valid, m_ready, m_data   | bfhs_pkg::out_item_t     | one result per command
//
// Visit, query and refused back/forward commands load the result register at the
// accepting edge. A back or forward that moves a page needs a read of one stack
// memory through its synchronous read port before the result is known, so it passes
// through ST_READ, where the result is loaded. Reset (aresetn low, synchronous) empties
// both stacks at once; memory contents are not cleared, as nothing below the depth
// counters is ever unwritten. A stalled result holds m_data; a new transaction is
// taken once the sequencer is idle and the output register is free or being drained
// in the same cycle.
`default_nettype none

module back_forward_history_stacks (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  bfhs_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output bfhs_pkg::out_item_t  m_data
);

    localparam int IDX_W  = bfhs_pkg::IDX_W;
    localparam int CNT_W  = bfhs_pkg::CNT_W;
    localparam int PAGE_W = bfhs_pkg::PAGE_W;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;   // ready for a transaction
    localparam logic ST_READ = 1'b1;   // stack read in flight, finish the move

    localparam logic [CNT_W-1:0] DEPTH_FULL = CNT_W'(bfhs_pkg::STACK_DEPTH);

    // stack memories
    logic [PAGE_W-1:0] back_mem [bfhs_pkg::STACK_DEPTH];
    logic [PAGE_W-1:0] fwd_mem  [bfhs_pkg::STACK_DEPTH];

    // control state
    logic             state_reg,   state_next;
    logic [IDX_W-1:0] bbase_reg,   bbase_next;
    logic [CNT_W-1:0] bdepth_reg,  bdepth_next;
    logic [CNT_W-1:0] fdepth_reg,  fdepth_next;
    logic             m_valid_reg;

    // payload state: copy of the back top so the result needs no second read
    logic [PAGE_W-1:0]             top_reg,    top_next;
    logic                          pend_fwd_reg, pend_fwd_next;
    logic [bfhs_pkg::STATUS_W-1:0] pend_st_reg,  pend_st_next;
    bfhs_pkg::out_item_t           out_reg,    out_next;

    // memory ports
    logic             bwr_en,  fwr_en,  brd_en,  frd_en;
    logic [IDX_W-1:0] bwr_addr, fwr_addr, brd_addr, frd_addr;
    logic [PAGE_W-1:0] bwr_data, fwr_data;
    logic [PAGE_W-1:0] brd_data_reg, frd_data_reg;

    logic out_free;
    logic accept;
    logic out_load;
    logic [bfhs_pkg::STATUS_W-1:0] status;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        state_next    = state_reg;
        bbase_next    = bbase_reg;
        bdepth_next   = bdepth_reg;
        fdepth_next   = fdepth_reg;
        top_next      = top_reg;
        pend_fwd_next = pend_fwd_reg;
        pend_st_next  = pend_st_reg;
        bwr_en   = 1'b0;
        bwr_addr = bbase_reg + bdepth_reg[IDX_W-1:0];
        bwr_data = s_data.page_id;
        fwr_en   = 1'b0;
        fwr_addr = fdepth_reg[IDX_W-1:0];
        fwr_data = top_reg;
        brd_en   = 1'b0;
        brd_addr = bbase_reg + bdepth_reg[IDX_W-1:0] - IDX_W'(2);
        frd_en   = 1'b0;
        frd_addr = fdepth_reg[IDX_W-1:0] - IDX_W'(1);
        out_load = 1'b0;
        status   = bfhs_pkg::ST_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.func)
                        bfhs_pkg::FUNC_VISIT: begin
                            // push slot is base+depth; on a full stack that is the
                            // oldest slot, which the base then steps past
                            bwr_en      = 1'b1;
                            top_next    = s_data.page_id;
                            fdepth_next = '0;
                            if (bdepth_reg == DEPTH_FULL) begin
                                bbase_next = bbase_reg + IDX_W'(1);
                                status     = bfhs_pkg::ST_DROPPED;
                            end else begin
                                bdepth_next = bdepth_reg + CNT_W'(1);
                            end
                            out_load = 1'b1;
                        end
                        bfhs_pkg::FUNC_BACK: begin
                            if (bdepth_reg < CNT_W'(2)) begin
                                status   = bfhs_pkg::ST_NO_PREV;
                                out_load = 1'b1;
                            end else begin
                                // fetch the entry under the top; old top goes forward now unless forward is full
                                brd_en        = 1'b1;
                                bdepth_next   = bdepth_reg - CNT_W'(1);
                                pend_fwd_next = 1'b0;
                                if (fdepth_reg == DEPTH_FULL) begin
                                    pend_st_next = bfhs_pkg::ST_LOST;
                                end else begin
                                    pend_st_next = bfhs_pkg::ST_OK;
                                    fwr_en       = 1'b1;
                                    fdepth_next  = fdepth_reg + CNT_W'(1);
                                end
                                state_next = ST_READ;
                            end
                        end
                        bfhs_pkg::FUNC_FORWARD: begin
                            if (fdepth_reg == '0) begin
                                status   = bfhs_pkg::ST_NO_NEXT;
                                out_load = 1'b1;
                            end else begin
                                frd_en        = 1'b1;
                                fdepth_next   = fdepth_reg - CNT_W'(1);
                                pend_fwd_next = 1'b1;
                                state_next    = ST_READ;
                            end
                        end
                        bfhs_pkg::FUNC_QUERY: begin
                            status   = (bdepth_reg == '0) ? bfhs_pkg::ST_NO_CUR
                                                          : bfhs_pkg::ST_OK;
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    if (pend_fwd_reg) begin
                        // push the fetched forward page onto the back stack
                        bwr_en   = 1'b1;
                        bwr_data = frd_data_reg;
                        top_next = frd_data_reg;
                        if (bdepth_reg == DEPTH_FULL) begin
                            bbase_next = bbase_reg + IDX_W'(1);
                            status     = bfhs_pkg::ST_DROPPED;
                        end else begin
                            bdepth_next = bdepth_reg + CNT_W'(1);
                        end
                    end else begin
                        top_next = brd_data_reg;
                        status   = pend_st_reg;
                    end
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result from the state after this transaction
        out_next.has_current   = (bdepth_next != '0);
        out_next.current_page  = out_next.has_current ? top_next : '0;
        out_next.back_count    = out_next.has_current
                               ? bfhs_pkg::BCOUNT_W'(bdepth_next - CNT_W'(1)) : '0;
        out_next.forward_count = bfhs_pkg::FCOUNT_W'(fdepth_next);
        out_next.status        = status;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bbase_reg   <= '0;
            bdepth_reg  <= '0;
            fdepth_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bbase_reg  <= bbase_next;
            bdepth_reg <= bdepth_next;
            fdepth_reg <= fdepth_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        pend_fwd_reg <= pend_fwd_next;
        pend_st_reg  <= pend_st_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // back stack memory
    always_ff @(posedge aclk) begin
        if (bwr_en) begin
            back_mem[bwr_addr] <= bwr_data;
        end
        if (brd_en) begin
            brd_data_reg <= back_mem[brd_addr];
        end
    end

    // forward stack memory
    always_ff @(posedge aclk) begin
        if (fwr_en) begin
            fwd_mem[fwr_addr] <= fwr_data;
        end
        if (frd_en) begin
            frd_data_reg <= fwd_mem[frd_addr];
        end
    end

endmodule

`default_nettype wire
